>>> rtl/hrfw_pkg.sv
// Shared types, constants and digit decoding for the hex record to flash write converter.
package hrfw_pkg;

  // Widths of the stream payloads and of the parser counters.
  localparam int CHAR_W  = 8;
  localparam int ADDR_W  = 32;
  localparam int HALF_W  = 16;
  localparam int POS_W   = 10;
  localparam int COUNT_W = 8;
  localparam int INDEX_W = 7;

  // Character position handling.
  localparam logic [POS_W-1:0] POS_MAX         = 10'd1023;
  localparam logic [POS_W-1:0] POS_COUNT_HI    = 10'd1;
  localparam logic [POS_W-1:0] POS_COUNT_LO    = 10'd2;
  localparam logic [POS_W-1:0] POS_ADDR_FIRST  = 10'd3;
  localparam logic [POS_W-1:0] POS_ADDR_LAST   = 10'd6;
  localparam logic [POS_W-1:0] POS_TYPE        = 10'd8;
  localparam logic [POS_W-1:0] POS_DATA_FIRST  = 10'd9;

  // ASCII codes used by the decoder.
  localparam logic [CHAR_W-1:0] ASCII_ZERO        = 8'd48;
  localparam logic [CHAR_W-1:0] ASCII_NINE        = 8'd57;
  localparam logic [CHAR_W-1:0] HEX_LETTER_OFFSET = 8'd55;
  localparam logic [CHAR_W-1:0] REC_TYPE_DATA     = 8'd48;

  // Reset value of the upper address half.
  localparam logic [HALF_W-1:0] ADDR_HIGH_RESET = 16'h0800;

  // Nibble slot of a data character within its four-character halfword group.
  typedef enum logic [1:0] {
    SLOT_LO_HI = 2'd0,
    SLOT_LO_LO = 2'd1,
    SLOT_HI_HI = 2'd2,
    SLOT_HI_LO = 2'd3
  } nibble_slot_t;

  // Decimal digits map directly; any other character is taken as a hex letter.
  function automatic logic [3:0] nibble_of(input logic [CHAR_W-1:0] c);
    logic [CHAR_W-1:0] diff;
    begin
      if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
        diff = c - ASCII_ZERO;
      end else begin
        diff = c - HEX_LETTER_OFFSET;
      end
      return diff[3:0];
    end
  endfunction

endpackage

>>> rtl/hex_record_to_flash_writes.sv
// Top level: parses Intel HEX characters and emits flash halfword writes.

// One character word is taken per clock with no gaps needed: the parser state
// updates on the accepting edge, and a halfword write is captured in the output
// register on that same edge and offered on the output from the next cycle, so
// sustained throughput is one character per cycle. The input stalls only while
// the output register holds an untaken word. s_axis_tuser high marks the colon
// character that opens a record.
// Data records (type '0') emit one write per four data characters, at address
// {cfg_data register, record address} + 2 * halfword number, with tlast on the
// final halfword of the record. Other record types and the checksum produce
// nothing; an odd trailing byte is dropped. The upper address register resets
// to 0x0800 and should be written only while the block is idle.
module hex_record_to_flash_writes
  import hrfw_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  // Configuration write channel: upper 16 address bits.
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [HALF_W-1:0] cfg_data,
  // Input characters.
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [CHAR_W-1:0] s_axis_tdata,   // [7:0] character
  input  logic              s_axis_tuser,   // [0] record_start
  // Output flash writes.
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [47:0]       m_axis_tdata,   // [31:0] write_address, [47:32] halfword
  output logic              m_axis_tlast    // last_of_record
);

  // Parser state.
  logic [HALF_W-1:0]  address_high_half;
  logic [POS_W-1:0]   char_position;
  logic [COUNT_W-1:0] byte_count;
  logic [HALF_W-1:0]  address_low_half;
  logic [HALF_W-1:0]  halfword_accumulator;
  logic               data_record_flag;
  logic [INDEX_W-1:0] halfword_index;

  logic [POS_W-1:0]   char_position_next;
  logic [COUNT_W-1:0] byte_count_next;
  logic [HALF_W-1:0]  address_low_half_next;
  logic [HALF_W-1:0]  halfword_accumulator_next;
  logic               data_record_flag_next;
  logic [INDEX_W-1:0] halfword_index_next;

  logic               in_accept;
  logic [3:0]         digit;
  logic [INDEX_W-1:0] half_count;
  nibble_slot_t       slot;
  logic               emit;
  logic [ADDR_W-1:0]  emit_address;
  logic               emit_last;

  // Output register.
  logic [ADDR_W-1:0]  out_address;
  logic [HALF_W-1:0]  out_halfword;
  logic               out_last;
  logic               out_valid;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = !out_valid || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign digit         = nibble_of(s_axis_tdata);
  assign half_count    = byte_count[COUNT_W-1:1];

  // Next position and the slot it lands on (data start is 9, so slot is pos - 1 mod 4).
  always_comb begin
    if (char_position != POS_MAX) begin
      char_position_next = char_position + 10'd1;
    end else begin
      char_position_next = char_position;
    end
    slot = nibble_slot_t'(char_position_next[1:0] + 2'd3);
  end

  // Field decode and halfword assembly for one character.
  always_comb begin
    byte_count_next           = byte_count;
    address_low_half_next     = address_low_half;
    halfword_accumulator_next = halfword_accumulator;
    data_record_flag_next     = data_record_flag;
    halfword_index_next       = halfword_index;
    emit                      = 1'b0;
    if (char_position_next == POS_COUNT_HI) begin
      byte_count_next = {digit, 4'h0};
    end else if (char_position_next == POS_COUNT_LO) begin
      byte_count_next = {byte_count[7:4], digit};
    end else if (char_position_next >= POS_ADDR_FIRST &&
                 char_position_next <= POS_ADDR_LAST) begin
      address_low_half_next = {address_low_half[11:0], digit};
    end else if (char_position_next == POS_TYPE) begin
      data_record_flag_next = (s_axis_tdata == REC_TYPE_DATA);
    end else if (char_position_next >= POS_DATA_FIRST) begin
      case (slot)
        SLOT_LO_HI: halfword_accumulator_next[7:4]   = digit;
        SLOT_LO_LO: halfword_accumulator_next[3:0]   = digit;
        SLOT_HI_HI: halfword_accumulator_next[15:12] = digit;
        SLOT_HI_LO: halfword_accumulator_next[11:8]  = digit;
        default:    halfword_accumulator_next        = halfword_accumulator;
      endcase
      if (slot == SLOT_HI_LO && data_record_flag && halfword_index < half_count) begin
        emit                = 1'b1;
        halfword_index_next = halfword_index + 7'd1;
      end
    end
  end

  // Flash address and end-of-record flag for the halfword being emitted.
  assign emit_address = {address_high_half, address_low_half} +
                        {{(ADDR_W-INDEX_W-1){1'b0}}, halfword_index, 1'b0};
  assign emit_last    = (halfword_index + 7'd1) == half_count;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      address_high_half <= ADDR_HIGH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      address_high_half <= cfg_data;
    end
  end

  // Parser state update on each accepted character word.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_position        <= '0;
      byte_count           <= '0;
      address_low_half     <= '0;
      halfword_accumulator <= '0;
      data_record_flag     <= 1'b0;
      halfword_index       <= '0;
    end else if (in_accept) begin
      if (s_axis_tuser) begin
        char_position        <= '0;
        data_record_flag     <= 1'b0;
        halfword_accumulator <= '0;
        halfword_index       <= '0;
      end else begin
        char_position        <= char_position_next;
        byte_count           <= byte_count_next;
        address_low_half     <= address_low_half_next;
        halfword_accumulator <= halfword_accumulator_next;
        data_record_flag     <= data_record_flag_next;
        halfword_index       <= halfword_index_next;
      end
    end
  end

  // Output register valid: set by an emitting word, cleared when taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= emit && !s_axis_tuser;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  // Output payload.
  always_ff @(posedge clk) begin
    if (in_accept && emit && !s_axis_tuser) begin
      out_address  <= emit_address;
      out_halfword <= halfword_accumulator_next;
      out_last     <= emit_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_halfword, out_address};
  assign m_axis_tlast  = out_last;

`ifndef SYNTHESIS
  // The halfword number never runs past half the byte count.
  a_index_bounded: assert property (@(posedge clk) disable iff (rst)
    halfword_index <= half_count)
    else $error("halfword index beyond byte count");

  // A record start clears the position and the halfword number.
  a_start_clears: assert property (@(posedge clk) disable iff (rst)
    (in_accept && s_axis_tuser) |=> (char_position == '0 && halfword_index == '0))
    else $error("record start did not clear parser state");

  // A new output word only follows an accepted character.
  a_out_from_input: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(in_accept))
    else $error("output word appeared without an input word");
`endif

endmodule
